[hw/rtl/bmd_pkg.sv]
package bmd_pkg;

  localparam int DEPTH     = 16;
  localparam int MSG_BITS  = 32;
  localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_BITS = 5;
  localparam int PEND_BITS = 16;
  localparam int KIND_BITS = 3;
  localparam int IN_BITS   = 32;
  localparam int OUT_BITS  = 56;

  localparam logic [PEND_BITS-1:0] PEND_MAX  = '1;
  localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(DEPTH);
  localparam logic [PTR_BITS-1:0]  PTR_LAST  = PTR_BITS'(DEPTH - 1);

  typedef enum logic [KIND_BITS-1:0] {
    K_PUSH_TAIL = 3'd0,
    K_PUSH_HEAD = 3'd1,
    K_POP       = 3'd2,
    K_CLEAR     = 3'd3,
    K_TASK_DONE = 3'd4
  } kind_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic queue_full;
  } stat_t;

endpackage

[hw/rtl/bmd_ctrl.sv]
module bmd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  bmd_pkg::stat_t stat,
  output bmd_pkg::cmd_t  cmd,
  output logic          busy
);
  import bmd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  state_t state;
  logic   accept;

  // take a new request once the pending result leaves
  assign s_tready = (state == S_IDLE) || (state == S_OUT && m_tready);
  assign m_tvalid = (state == S_OUT);
  assign accept   = s_tvalid && s_tready;

  assign cmd.load = accept;
  assign cmd.exec = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (accept) begin
            state <= S_EXEC;
          end else if (m_tready) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
      // status is only sampled to force the controller idle if the ring reads both full and empty
      if (stat.queue_full && stat.queue_empty) begin
        state <= S_IDLE;
        busy  <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/bmd_dpath.sv]
module bmd_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  bmd_pkg::cmd_t                cmd,
  output bmd_pkg::stat_t               stat,
  input  logic [bmd_pkg::KIND_BITS-1:0] kind,
  input  logic [bmd_pkg::IN_BITS-1:0]   msg_in,
  output logic                         ok,
  output logic [bmd_pkg::IN_BITS-1:0]   msg_out,
  output logic [bmd_pkg::FILL_BITS-1:0] fill,
  output logic [bmd_pkg::PEND_BITS-1:0] unfinished,
  output logic                         all_done
);
  import bmd_pkg::*;

  logic [MSG_BITS-1:0]  slots [DEPTH];
  logic [KIND_BITS-1:0] req_kind;
  logic [MSG_BITS-1:0]  req_msg;

  logic [PTR_BITS-1:0]  front_ptr, front_ptr_next;
  logic [FILL_BITS-1:0] held, held_next;
  logic [PEND_BITS-1:0] pending_ct, pending_ct_next;

  logic                 wr_en;
  logic [PTR_BITS-1:0]  wr_addr;
  logic [PTR_BITS:0]    tail_sum;
  logic [PTR_BITS-1:0]  tail_ptr;
  logic [PTR_BITS-1:0]  prev_ptr;
  logic [PTR_BITS-1:0]  succ_ptr;
  logic                 pop_ok;
  logic                 ok_next;
  logic                 full;
  logic                 empty;

  assign full  = (held == FILL_FULL);
  assign empty = (held == '0);
  assign stat.queue_full  = full;
  assign stat.queue_empty = empty;

  // ring arithmetic: both sums stay below twice the depth
  assign tail_sum = {1'b0, front_ptr} + (PTR_BITS+1)'(held);
  assign tail_ptr = (tail_sum >= (PTR_BITS+1)'(DEPTH)) ?
                    PTR_BITS'(tail_sum - (PTR_BITS+1)'(DEPTH)) : tail_sum[PTR_BITS-1:0];
  assign prev_ptr = (front_ptr == '0) ? PTR_LAST : front_ptr - PTR_BITS'(1);
  assign succ_ptr = (front_ptr == PTR_LAST) ? '0 : front_ptr + PTR_BITS'(1);

  always_comb begin
    front_ptr_next  = front_ptr;
    held_next       = held;
    pending_ct_next = pending_ct;
    wr_en           = 1'b0;
    wr_addr         = tail_ptr;
    pop_ok          = 1'b0;
    ok_next         = 1'b0;
    case (req_kind)
      K_PUSH_TAIL: begin
        if (!full) begin
          wr_en     = 1'b1;
          held_next = held + FILL_BITS'(1);
          ok_next   = 1'b1;
          if (pending_ct != PEND_MAX) pending_ct_next = pending_ct + PEND_BITS'(1);
        end
      end
      K_PUSH_HEAD: begin
        if (!full) begin
          wr_en          = 1'b1;
          wr_addr        = prev_ptr;
          front_ptr_next = prev_ptr;
          held_next      = held + FILL_BITS'(1);
          ok_next        = 1'b1;
          if (pending_ct != PEND_MAX) pending_ct_next = pending_ct + PEND_BITS'(1);
        end
      end
      K_POP: begin
        if (!empty) begin
          pop_ok         = 1'b1;
          front_ptr_next = succ_ptr;
          held_next      = held - FILL_BITS'(1);
          ok_next        = 1'b1;
        end
      end
      K_CLEAR: begin
        front_ptr_next  = '0;
        held_next       = '0;
        pending_ct_next = '0;
        ok_next         = 1'b1;
      end
      K_TASK_DONE: begin
        if (pending_ct != '0) begin
          pending_ct_next = pending_ct - PEND_BITS'(1);
          ok_next         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr  <= '0;
      held       <= '0;
      pending_ct <= '0;
    end else if (cmd.exec) begin
      front_ptr  <= front_ptr_next;
      held       <= held_next;
      pending_ct <= pending_ct_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind;
      req_msg  <= msg_in[MSG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slots[wr_addr] <= req_msg;
    end
  end

  // result register, holds until the next request executes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok         <= ok_next;
      msg_out    <= pop_ok ? IN_BITS'(slots[front_ptr]) : '0;
      fill       <= held_next;
      unfinished <= pending_ct_next;
      all_done   <= (pending_ct_next == '0);
    end
  end

endmodule

[hw/rtl/bounded_message_deque.sv]
// Bounded message deque: a ring of 16 slots of 32-bit messages with push to
// tail, urgent push to head, pop, clear and task-done requests, each
// answered by exactly one result. A request is captured when it is taken and
// executed in the next cycle, where ring pointers, fill and pending counters
// update and the front slot is read into the result register; the result
// is shown the cycle after, as the controller moves from capture to its
// execute and output states. While a result waits, the next request is
// taken in the same cycle the result is taken. A push to a full ring or a
// pop from an empty one fails with ok low, and the pending count saturates
// at zero and at 65535.
module bounded_message_deque (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] msg_in
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // [0] ok, [32:1] msg_out, [37:33] fill,
                                 // [53:38] unfinished, [54] all_done, [55] zero
);
  import bmd_pkg::*;

  cmd_t                 cmd;
  stat_t                stat;
  logic                 busy;
  logic                 ok;
  logic [IN_BITS-1:0]   msg_out;
  logic [FILL_BITS-1:0] fill;
  logic [PEND_BITS-1:0] unfinished;
  logic                 all_done;

  bmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  bmd_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (s_tuser),
    .msg_in     (s_tdata),
    .ok         (ok),
    .msg_out    (msg_out),
    .fill       (fill),
    .unfinished (unfinished),
    .all_done   (all_done)
  );

  assign m_tdata = {1'b0, all_done, unfinished, fill, msg_out, ok};

  // a waiting result blocks new requests
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while result stalled");

  // each accepted request yields a result after its execute step
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!m_tvalid ##1 m_tvalid))
    else $error("result timing broken");

  // fill never exceeds the depth
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:33] <= 5'(DEPTH)))
    else $error("fill beyond depth");

  // the controller is busy whenever a result is shown
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> busy)
    else $error("result without busy controller");

endmodule
